FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("forbidden condition seen");

`endif

FILE: rtl/asn1tc_pkg.sv
// Types, constants and helper functions of the ASN.1 time string parser.
// Depends on nothing; used by the step, result and top-level modules.
`timescale 1ns / 1ps

package asn1tc_pkg;

  localparam int POS_W = 6;
  localparam int ACC_W = 14;
  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam logic [POS_W-1:0] DATE_LEN_GEN = 6'd14;
  localparam logic [POS_W-1:0] DATE_LEN_UTC = 6'd12;
  localparam logic [POS_W-1:0] UTC_SEC_POS  = 6'd10;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [ACC_W-1:0] UTC_PIVOT = 14'd49;
  localparam logic [ACC_W-1:0] YEAR_1900 = 14'd1900;
  localparam logic [ACC_W-1:0] YEAR_MIN  = 14'd2000;
  localparam logic [ACC_W-1:0] YEAR_MAX  = 14'd2099;

  localparam logic signed [13:0] ZONE_NONE  = 14'sd2047;
  localparam logic signed [13:0] ZONE_LIMIT = 14'sd1440;

  typedef enum logic [1:0] {
    PH_DATE,
    PH_FRAC,
    PH_ZONE,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    ZK_NONE,
    ZK_Z,
    ZK_PLUS,
    ZK_MINUS
  } zone_kind_t;

  // Running parse state; the fraction is kept already scaled to milliseconds
  // and the zone as separate hour and minute digit pairs.
  typedef struct packed {
    logic [POS_W-1:0]         pos;
    phase_t                   phase;
    logic [5:0][ACC_W-1:0]    acc;
    logic [9:0]               frac_ms;
    logic [2:0]               frac_cnt;
    logic [6:0]               zone_hh;
    logic [6:0]               zone_mm;
    logic [2:0]               zone_cnt;
    zone_kind_t               zone_kind;
    logic                     fmt_err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    pos:       '0,
    phase:     PH_DATE,
    acc:       '0,
    frac_ms:   '0,
    frac_cnt:  '0,
    zone_hh:   '0,
    zone_mm:   '0,
    zone_cnt:  '0,
    zone_kind: ZK_NONE,
    fmt_err:   1'b0
  };

  typedef struct packed {
    logic [13:0]        year;
    logic [6:0]         month;
    logic [6:0]         day_of_month;
    logic [6:0]         hour;
    logic [6:0]         minute;
    logic [6:0]         second;
    logic [29:0]        nanosecond;
    logic signed [13:0] zone_offset;
    logic               time_ok;
  } result_t;

  // Days in a month, index 0 for January; February allows the leap day.
  function automatic logic [4:0] month_days(input logic [3:0] idx);
    logic [4:0] days;
    unique case (idx)
      4'd1:                      days = 5'd29;
      4'd3, 4'd5, 4'd8, 4'd10:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

FILE: rtl/asn1tc_step.sv
// Next-state logic for one character of the time string.
// Depends on asn1tc_pkg.
`timescale 1ns / 1ps

module asn1tc_step #(
  parameter int MAX_CHARS = 32
) (
  input  asn1tc_pkg::parse_state_t st,
  input  logic                     gen,
  input  logic [7:0]               ch,
  input  logic                     last,
  output asn1tc_pkg::parse_state_t nxt
);
  import asn1tc_pkg::*;

  localparam logic [POS_W-1:0] OVERLONG_POS = POS_W'(MAX_CHARS - 1);

  logic                   is_dig;
  logic [3:0]             dig;
  logic [POS_W-1:0]       date_len;
  logic [3:0]             pos_lo;
  logic [2:0]             fsel;
  logic [ACC_W-1:0]       acc_sel;
  logic [ACC_W+3:0]       mac_full;
  logic [9:0]             ms_add;
  logic [2:0]             zone_cnt_inc;

  // Character after the date or the fraction: dot, Z, sign or an error.
  function automatic parse_state_t apply_suffix(input parse_state_t s,
                                                input logic [7:0] c,
                                                input logic g,
                                                input logic dot_ok);
    parse_state_t r;
    r = s;
    priority if (c == CH_DOT && g && dot_ok) begin
      r.phase = PH_FRAC;
    end else if (c == CH_Z) begin
      r.zone_kind = ZK_Z;
      r.phase     = PH_END;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r.zone_kind = (c == CH_PLUS) ? ZK_PLUS : ZK_MINUS;
      r.phase     = PH_ZONE;
    end else begin
      r.fmt_err = 1'b1;
      r.phase   = PH_END;
    end
    return r;
  endfunction

  assign is_dig   = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dig      = ch[3:0];
  assign date_len = gen ? DATE_LEN_GEN : DATE_LEN_UTC;
  assign pos_lo   = st.pos[3:0];

  // Pick the date field that this position feeds.
  always_comb begin
    logic [2:0] f;
    if (gen) begin
      f = (pos_lo < 4'd4) ? 3'd0 : 3'((pos_lo - 4'd2) >> 1);
    end else begin
      f = 3'(pos_lo >> 1);
    end
    fsel = (f > 3'd5) ? 3'd5 : f;
  end

  // Multiply the selected field by ten and add the digit.
  assign acc_sel  = st.acc[fsel];
  assign mac_full = (ACC_W+4)'({acc_sel, 3'b000}) + (ACC_W+4)'({acc_sel, 1'b0})
                  + (ACC_W+4)'(dig);

  // Weight of a fraction digit in milliseconds.
  always_comb begin
    unique case (st.frac_cnt[1:0])
      2'd0:    ms_add = 10'(dig) * 10'd100;
      2'd1:    ms_add = 10'(dig) * 10'd10;
      default: ms_add = 10'(dig);
    endcase
  end

  assign zone_cnt_inc = st.zone_cnt + 3'd1;

  always_comb begin
    nxt = st;
    if (st.pos >= OVERLONG_POS && !last) begin
      nxt.fmt_err = 1'b1;
    end

    unique case (st.phase)
      PH_DATE: begin
        if (st.pos >= date_len || (!gen && st.pos == UTC_SEC_POS && !is_dig)) begin
          nxt = apply_suffix(nxt, ch, gen, 1'b1);
        end else if (is_dig) begin
          nxt.acc[fsel] = mac_full[ACC_W-1:0];
        end else begin
          nxt.fmt_err = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          if (st.frac_cnt < 3'd3) begin
            nxt.frac_ms = st.frac_ms + ms_add;
          end
          if (st.frac_cnt != 3'd7) begin
            nxt.frac_cnt = st.frac_cnt + 3'd1;
          end
        end else if (st.frac_cnt == 3'd0) begin
          nxt.fmt_err = 1'b1;
          nxt.phase   = PH_END;
        end else begin
          nxt = apply_suffix(nxt, ch, gen, 1'b0);
        end
      end
      PH_ZONE: begin
        if (is_dig) begin
          if (st.zone_cnt < 3'd2) begin
            nxt.zone_hh = 7'(10'({st.zone_hh, 3'b000}) + 10'({st.zone_hh, 1'b0})
                             + 10'(dig));
          end else begin
            nxt.zone_mm = 7'(10'({st.zone_mm, 3'b000}) + 10'({st.zone_mm, 1'b0})
                             + 10'(dig));
          end
          nxt.zone_cnt = zone_cnt_inc;
          if (zone_cnt_inc >= 3'd4) begin
            nxt.phase = PH_END;
          end
        end else begin
          nxt.fmt_err = 1'b1;
          nxt.phase   = PH_END;
        end
      end
      default: begin
        nxt.fmt_err = 1'b1;
      end
    endcase

    // Advance the position, saturating at the top.
    if (st.pos != POS_MAX) begin
      nxt.pos = st.pos + POS_W'(1);
    end
  end

endmodule

FILE: rtl/asn1tc_result.sv
// Result fields and calendar checks from the state after the last character.
// Depends on asn1tc_pkg.
`timescale 1ns / 1ps

module asn1tc_result (
  input  asn1tc_pkg::parse_state_t s,
  input  logic                     gen,
  output asn1tc_pkg::result_t      res
);
  import asn1tc_pkg::*;

  logic [POS_W-1:0]    date_len;
  logic                err_end;
  logic [ACC_W-1:0]    yr0;
  logic [ACC_W-1:0]    year;
  logic [ACC_W-1:0]    month;
  logic [ACC_W-1:0]    day;
  logic [3:0]          mon_idx;
  logic [12:0]         zone_mag;
  logic signed [13:0]  offset;
  logic                date_ok;
  logic                day_ok;
  logic                clock_ok;
  logic                zone_ok;
  logic                leap;

  assign date_len = gen ? DATE_LEN_GEN : DATE_LEN_UTC;

  // Flag format errors and strings that stop inside the date, right after the dot or in a zone.
  assign err_end = s.fmt_err
                 | (s.phase == PH_DATE
                    && !(s.pos == date_len || (!gen && s.pos == UTC_SEC_POS)))
                 | (s.phase == PH_FRAC && s.frac_cnt == 3'd0)
                 | (s.phase == PH_ZONE);

  // Expand a two-digit year around the pivot.
  assign yr0 = s.acc[0];
  always_comb begin
    if (gen) begin
      year = yr0;
    end else if (yr0 > UTC_PIVOT) begin
      year = yr0 + YEAR_1900;
    end else begin
      year = yr0 + YEAR_MIN;
    end
  end

  // Build the zone offset in minutes.
  assign zone_mag = 13'(s.zone_hh) * 13'd60 + 13'(s.zone_mm);
  always_comb begin
    unique case (s.zone_kind)
      ZK_Z:     offset = '0;
      ZK_PLUS:  offset = (s.zone_cnt >= 3'd4) ? 14'(zone_mag) : ZONE_NONE;
      ZK_MINUS: offset = (s.zone_cnt >= 3'd4) ? -14'(zone_mag) : ZONE_NONE;
      default:  offset = ZONE_NONE;
    endcase
  end

  // Calendar checks; inside 2000..2099 a leap year is one divisible by four.
  assign month    = s.acc[1];
  assign day      = s.acc[2];
  assign mon_idx  = 4'(month - 14'd1);
  assign leap     = (year[1:0] == 2'b00);
  assign date_ok  = !err_end && year >= YEAR_MIN && year <= YEAR_MAX
                  && month >= 14'd1 && month <= 14'd12;
  assign day_ok   = day >= 14'd1 && day <= 14'(month_days(mon_idx))
                  && !(month == 14'd2 && !leap && day > 14'd28);
  assign clock_ok = s.acc[3] <= 14'd23 && s.acc[4] <= 14'd59 && s.acc[5] <= 14'd59;
  assign zone_ok  = (offset == ZONE_NONE) || (offset >= -ZONE_LIMIT && offset <= ZONE_LIMIT);

  always_comb begin
    res.year         = year;
    res.month        = month[6:0];
    res.day_of_month = day[6:0];
    res.hour         = s.acc[3][6:0];
    res.minute       = s.acc[4][6:0];
    res.second       = s.acc[5][6:0];
    res.nanosecond   = (s.frac_cnt >= 3'd1 && s.frac_cnt <= 3'd3)
                     ? 30'(30'(s.frac_ms) * 30'd1000000) : '0;
    res.zone_offset  = offset;
    res.time_ok      = date_ok && day_ok && clock_ok && zone_ok;
  end

endmodule

FILE: rtl/asn1_time_string_to_calendar_top.sv
// Top level of the ASN.1 time string parser: input register, parse state, result register.
// Depends on asn1tc_pkg, asn1tc_step, asn1tc_result and assert_macros.svh.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_req_type/ch/last | into block
//   out     | out_valid, out_stall, out_* fields      | out of block
//
// One character is taken every cycle while in_stall is low. A character is
// held in the input register, then updates the parse state; the last one
// loads the result register, which drives the out_* fields.
// Synchronous reset clears the parse state at once; no clearing pass.
// A stalled result blocks input only when the held character is a last one.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module asn1_time_string_to_calendar_top #(
  parameter int MAX_CHARS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        out_year,
  output logic [6:0]         out_month,
  output logic [6:0]         out_day_of_month,
  output logic [6:0]         out_hour,
  output logic [6:0]         out_minute,
  output logic [6:0]         out_second,
  output logic [29:0]        out_nanosecond,
  output logic signed [13:0] out_zone_offset,
  output logic               out_time_ok
);
  import asn1tc_pkg::*;

  logic         s1_valid_r, s1_valid_nxt;
  logic         s1_req_type_r;
  logic [7:0]   s1_ch_r;
  logic         s1_last_r;
  parse_state_t st_r, st_nxt;
  parse_state_t step_st;
  result_t      res;
  result_t      res_r;
  logic         out_valid_r, out_valid_nxt;
  logic         out_free;
  logic         advance;
  logic         in_take;

  // Process the held character unless its result has nowhere to go.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  asn1tc_step #(
    .MAX_CHARS(MAX_CHARS)
  ) u_step (
    .st   (st_r),
    .gen  (s1_req_type_r),
    .ch   (s1_ch_r),
    .last (s1_last_r),
    .nxt  (step_st)
  );

  asn1tc_result u_result (
    .s   (step_st),
    .gen (s1_req_type_r),
    .res (res)
  );

  // Next values of the control registers.
  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    st_nxt        = st_r;
    if (advance) begin
      st_nxt = s1_last_r ? PARSE_RESET : step_st;
    end
    out_valid_nxt = out_valid_r;
    if (advance && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= PARSE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the accepted character.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_type_r <= in_req_type;
      s1_ch_r       <= in_ch;
      s1_last_r     <= in_last;
    end
  end

  // Load the result register on the last character.
  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_year         = res_r.year;
  assign out_month        = res_r.month;
  assign out_day_of_month = res_r.day_of_month;
  assign out_hour         = res_r.hour;
  assign out_minute       = res_r.minute;
  assign out_second       = res_r.second;
  assign out_nanosecond   = res_r.nanosecond;
  assign out_zone_offset  = res_r.zone_offset;
  assign out_time_ok      = res_r.time_ok;

  // Input blocks only behind a last character facing a stalled result.
  `ASSERT_CLK(a_stall_cause, clk, rst_n,
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
  // Parse state starts over after every last character.
  `ASSERT_CLK(a_restart, clk, rst_n,
    (advance && s1_last_r) |=> (st_r.pos == '0 && st_r.phase == PH_DATE && !st_r.fmt_err))
  // A passing result has a month and a year in range.
  `ASSERT_CLK(a_ok_month, clk, rst_n,
    (out_valid && out_time_ok) |-> (out_month >= 7'd1 && out_month <= 7'd12))
  `ASSERT_CLK(a_ok_year, clk, rst_n,
    (out_valid && out_time_ok) |-> (out_year >= 14'd2000 && out_year <= 14'd2099))

endmodule
